[src/rrpr_pkg.sv]
// Shared types and constants for the rounded rectangle rasterizer.
// No dependencies.
`default_nettype none

package rrpr_pkg;

   localparam int RADIUS_BITS   = 9;
   localparam int COLOR_BITS    = 16;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;
   // (radius + 1)^2 with radius up to 511 fits in 19 bits
   localparam int RAD_SQ_BITS   = 19;

   typedef logic [CSR_IDX_BITS-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_BITS-1:0] csr_data_type;
   typedef logic [COLOR_BITS-1:0]    color_type;
   typedef logic [RADIUS_BITS-1:0]   radius_type;
   typedef logic [RAD_SQ_BITS-1:0]   rad_sq_type;

   localparam csr_idx_type CSR_LEFT_X        = 3'd0;
   localparam csr_idx_type CSR_TOP_Y         = 3'd1;
   localparam csr_idx_type CSR_RIGHT_X       = 3'd2;
   localparam csr_idx_type CSR_BOTTOM_Y      = 3'd3;
   localparam csr_idx_type CSR_CORNER_RADIUS = 3'd4;
   localparam csr_idx_type CSR_FILL_COLOR    = 3'd5;
   localparam csr_idx_type CSR_OUTSIDE_COLOR = 3'd6;

   // per-stage pipeline token
   typedef struct packed {
      logic valid;
      logic last;
   } tok_type;

endpackage

`default_nettype wire

[src/rrpr_ifs.sv]
// Valid/ready channel interfaces: pixel request, pixel result, register write.
// Depends on rrpr_pkg.
`default_nettype none

interface rrpr_req_if;
   logic valid;
   logic ready;
   logic restart;
   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface rrpr_rsp_if import rrpr_pkg::*;;
   logic      valid;
   logic      ready;
   color_type pixel_color;
   logic      last_pixel;
   modport source (output valid, output pixel_color, output last_pixel, input ready);
   modport sink   (input valid, input pixel_color, input last_pixel, output ready);
endinterface

interface rrpr_csr_if import rrpr_pkg::*;;
   logic         valid;
   logic         ready;
   csr_idx_type  index;
   csr_data_type data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/rrpr_csr.sv]
// Register file plus derived window geometry (centre, corner offsets, radius square).
// Depends on rrpr_pkg and rrpr_ifs.
`default_nettype none

module rrpr_csr import rrpr_pkg::*; #(
   parameter int COORD_BITS = 10,
   parameter int OFF_BITS   = 12
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   rrpr_csr_if.sink                         csr,
   output logic        [COORD_BITS-1:0]     left_o,
   output logic        [COORD_BITS-1:0]     top_o,
   output logic        [COORD_BITS-1:0]     span_x_o,
   output logic        [COORD_BITS-1:0]     span_y_o,
   output logic        [COORD_BITS-1:0]     cx_o,
   output logic        [COORD_BITS-1:0]     cy_o,
   output logic signed [OFF_BITS-1:0]       off_x_o,
   output logic signed [OFF_BITS-1:0]       off_y_o,
   output rad_sq_type                       rad_sq_o,
   output color_type                        fill_o,
   output color_type                        outside_o
);

   localparam int PROD_BITS = 2 * (RADIUS_BITS + 1);

   logic [COORD_BITS-1:0] left_ff, top_ff, right_ff, bottom_ff;
   radius_type            radius_ff;
   color_type             fill_ff, outside_ff;

   logic [COORD_BITS-1:0] r_eff, b_eff, hx, hy, cx, cy;
   logic [COORD_BITS:0]   sum_x, sum_y;
   logic [RADIUS_BITS:0]  rad_p1;
   logic [PROD_BITS-1:0]  rad_p1_w, rad_prod;

   logic [COORD_BITS-1:0]     cx_ff, cy_ff;
   logic signed [OFF_BITS-1:0] off_x_ff, off_y_ff;
   rad_sq_type                rad_sq_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff    <= '0;
         top_ff     <= '0;
         right_ff   <= '0;
         bottom_ff  <= '0;
         radius_ff  <= '0;
         fill_ff    <= '0;
         outside_ff <= '0;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_LEFT_X:        left_ff    <= csr.data[COORD_BITS-1:0];
            CSR_TOP_Y:         top_ff     <= csr.data[COORD_BITS-1:0];
            CSR_RIGHT_X:       right_ff   <= csr.data[COORD_BITS-1:0];
            CSR_BOTTOM_Y:      bottom_ff  <= csr.data[COORD_BITS-1:0];
            CSR_CORNER_RADIUS: radius_ff  <= csr.data[RADIUS_BITS-1:0];
            CSR_FILL_COLOR:    fill_ff    <= csr.data[COLOR_BITS-1:0];
            CSR_OUTSIDE_COLOR: outside_ff <= csr.data[COLOR_BITS-1:0];
            default: ;
         endcase
      end
   end

   // reversed edges collapse to a single column / row
   always_comb begin
      r_eff    = (right_ff < left_ff) ? left_ff : right_ff;
      b_eff    = (bottom_ff < top_ff) ? top_ff : bottom_ff;
      sum_x    = {1'b0, left_ff} + {1'b0, r_eff};
      sum_y    = {1'b0, top_ff} + {1'b0, b_eff};
      cx       = sum_x[COORD_BITS:1];
      cy       = sum_y[COORD_BITS:1];
      hx       = r_eff - cx;
      hy       = b_eff - cy;
      rad_p1   = {1'b0, radius_ff} + 1'b1;
      rad_p1_w = PROD_BITS'(rad_p1);
      rad_prod = rad_p1_w * rad_p1_w;
   end

   // geometry used from the second pipeline stage on
   always_ff @(posedge clock) begin
      cx_ff     <= cx;
      cy_ff     <= cy;
      off_x_ff  <= signed'(OFF_BITS'(hx)) - signed'(OFF_BITS'(radius_ff));
      off_y_ff  <= signed'(OFF_BITS'(hy)) - signed'(OFF_BITS'(radius_ff));
      rad_sq_ff <= rad_prod[RAD_SQ_BITS-1:0];
   end

   assign left_o    = left_ff;
   assign top_o     = top_ff;
   assign span_x_o  = r_eff - left_ff;
   assign span_y_o  = b_eff - top_ff;
   assign cx_o      = cx_ff;
   assign cy_o      = cy_ff;
   assign off_x_o   = off_x_ff;
   assign off_y_o   = off_y_ff;
   assign rad_sq_o  = rad_sq_ff;
   assign fill_o    = fill_ff;
   assign outside_o = outside_ff;

endmodule

`default_nettype wire

[src/rrpr_scan.sv]
// Raster scan position and first pipeline stage (pixel position register).
// Depends on rrpr_pkg.
`default_nettype none

module rrpr_scan import rrpr_pkg::*; #(
   parameter int COORD_BITS = 10
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_restart,
   input  wire logic                  adv,
   input  wire logic [COORD_BITS-1:0] span_x,
   input  wire logic [COORD_BITS-1:0] span_y,
   output logic      [COORD_BITS:0]   col_o,
   output logic      [COORD_BITS:0]   row_o,
   output tok_type                    tok_o,
   output logic      [COORD_BITS:0]   scan_col_o
);

   localparam int POS_BITS = COORD_BITS + 1;

   logic [POS_BITS-1:0] scan_col_ff, scan_row_ff;
   logic [POS_BITS-1:0] col, row;
   logic [POS_BITS-1:0] col_s1_ff, row_s1_ff;
   logic                last_s1_ff, valid_s1_ff;
   logic                end_row, last_row, fire;

   always_comb begin
      fire     = req_valid && adv;
      col      = req_restart ? '0 : scan_col_ff;
      row      = req_restart ? '0 : scan_row_ff;
      end_row  = col >= POS_BITS'(span_x);
      last_row = row >= POS_BITS'(span_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_col_ff <= '0;
         scan_row_ff <= '0;
         valid_s1_ff <= 1'b0;
      end else begin
         if (adv) begin
            valid_s1_ff <= req_valid;
         end
         if (fire) begin
            if (end_row) begin
               scan_col_ff <= '0;
               scan_row_ff <= last_row ? '0 : row + 1'b1;
            end else begin
               scan_col_ff <= col + 1'b1;
               scan_row_ff <= row;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         col_s1_ff  <= col;
         row_s1_ff  <= row;
         last_s1_ff <= end_row && last_row;
      end
   end

   assign col_o       = col_s1_ff;
   assign row_o       = row_s1_ff;
   assign tok_o.valid = valid_s1_ff;
   assign tok_o.last  = last_s1_ff;
   assign scan_col_o  = scan_col_ff;

endmodule

`default_nettype wire

[src/rrpr_shade.sv]
// Corner test, distance squares and colour pick: three stages ending in the result register.
// Depends on rrpr_pkg.
`default_nettype none

module rrpr_shade import rrpr_pkg::*; #(
   parameter int COORD_BITS = 10,
   parameter int OFF_BITS   = 12
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic        [COORD_BITS:0]  col,
   input  wire logic        [COORD_BITS:0]  row,
   input  wire tok_type                     tok_s1,
   input  wire logic        [COORD_BITS-1:0] left_x,
   input  wire logic        [COORD_BITS-1:0] top_y,
   input  wire logic        [COORD_BITS-1:0] cx,
   input  wire logic        [COORD_BITS-1:0] cy,
   input  wire logic signed [OFF_BITS-1:0]  off_x,
   input  wire logic signed [OFF_BITS-1:0]  off_y,
   input  wire rad_sq_type                  rad_sq,
   input  wire color_type                   fill,
   input  wire color_type                   outside,
   input  wire logic                        rsp_ready,
   output logic                             rsp_valid,
   output color_type                        rsp_color,
   output logic                             rsp_last,
   output logic                             adv
);

   localparam int W       = OFF_BITS + 2;
   localparam int DXW     = W - 1;
   localparam int SQW     = 2 * DXW;
   localparam int SUMW    = SQW + 1;

   logic signed [W-1:0] x, y, ax, ay, ox, oy, dx, dy;
   logic                corner;

   tok_type          tok_s2_ff, tok_s3_ff;
   logic             corner_s2_ff, corner_s3_ff;
   logic [DXW-1:0]   dx_s2_ff, dy_s2_ff;
   logic [SQW-1:0]   sqx_s3_ff, sqy_s3_ff;
   logic [SUMW-1:0]  dist_sq;

   logic             out_valid_ff, out_last_ff;
   color_type        out_color_ff;

   // whole pipe moves whenever the result slot is empty or being taken
   assign adv = !out_valid_ff || rsp_ready;

   // centre-relative position and corner offsets
   always_comb begin
      x      = signed'(W'(left_x)) + signed'(W'(col)) - signed'(W'(cx));
      y      = signed'(W'(top_y)) + signed'(W'(row)) - signed'(W'(cy));
      ax     = x[W-1] ? -x : x;
      ay     = y[W-1] ? -y : y;
      ox     = W'(off_x);
      oy     = W'(off_y);
      corner = (ax >= ox) && (ay >= oy);
      dx     = ax - ox;
      dy     = ay - oy;
   end

   assign dist_sq = SUMW'(sqx_s3_ff) + SUMW'(sqy_s3_ff);

   // valid bits reset, data follows the valid bits down the pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_s2_ff.valid <= 1'b0;
         tok_s3_ff.valid <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else if (adv) begin
         tok_s2_ff.valid <= tok_s1.valid;
         tok_s3_ff.valid <= tok_s2_ff.valid;
         out_valid_ff    <= tok_s3_ff.valid;

         tok_s2_ff.last <= tok_s1.last;
         corner_s2_ff   <= corner;
         dx_s2_ff       <= dx[DXW-1:0];
         dy_s2_ff       <= dy[DXW-1:0];

         tok_s3_ff.last <= tok_s2_ff.last;
         corner_s3_ff   <= corner_s2_ff;
         sqx_s3_ff      <= SQW'(dx_s2_ff) * SQW'(dx_s2_ff);
         sqy_s3_ff      <= SQW'(dy_s2_ff) * SQW'(dy_s2_ff);

         out_last_ff    <= tok_s3_ff.last;
         out_color_ff   <= (corner_s3_ff && (dist_sq > SUMW'(rad_sq))) ? outside : fill;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_color = out_color_ff;
   assign rsp_last  = out_last_ff;

endmodule

`default_nettype wire

[src/rounded_rect_pixel_rasterizer.sv]
// Top level of the rounded rectangle rasterizer: register port, scan, colour pipeline.
// Depends on rrpr_pkg, rrpr_ifs, rrpr_csr, rrpr_scan and rrpr_shade.
`default_nettype none

// Streams the RGB565 colour of every pixel of a rectangular window in raster
// order, one pixel per request transfer. A request with restart set emits the
// top-left pixel; otherwise the next pixel of the scan is emitted, wrapping to
// the top-left after the bottom-right one (flagged by last_pixel). Pixels in
// the four corner zones get fill_color only inside the rounding circle of
// radius corner_radius + 1, outside_color beyond it; all others get
// fill_color. Throughput is one pixel per clock while results are taken. A
// request is turned into a result over four register levels (position, corner
// distances, squares, result register). The whole pipe halts only while a
// result waits untaken; req ready then drops. Registers are written through
// the csr channel (always ready) and must only be changed with no pixel in
// flight; a write takes effect on the next pixel.

module rounded_rect_pixel_rasterizer import rrpr_pkg::*; #(
   parameter int COORD_BITS = 10
) (
   input  wire logic  clock,
   input  wire logic  reset,
   rrpr_req_if.sink   req_ch,
   rrpr_rsp_if.source rsp_ch,
   rrpr_csr_if.sink   csr_ch
);

   // corner offsets can go negative by up to the radius
   localparam int OFF_BITS = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

   logic        [COORD_BITS-1:0] left_x, top_y, span_x, span_y, cx, cy;
   logic signed [OFF_BITS-1:0]   off_x, off_y;
   rad_sq_type                   rad_sq;
   color_type                    fill, outside;

   logic [COORD_BITS:0] col_s1, row_s1, scan_col;
   tok_type             tok_s1;
   logic                adv;

   rrpr_csr #(
      .COORD_BITS (COORD_BITS),
      .OFF_BITS   (OFF_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ch),
      .left_o    (left_x),
      .top_o     (top_y),
      .span_x_o  (span_x),
      .span_y_o  (span_y),
      .cx_o      (cx),
      .cy_o      (cy),
      .off_x_o   (off_x),
      .off_y_o   (off_y),
      .rad_sq_o  (rad_sq),
      .fill_o    (fill),
      .outside_o (outside)
   );

   // scan counter; span is the window width/height minus one
   rrpr_scan #(
      .COORD_BITS (COORD_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_restart (req_ch.restart),
      .adv         (adv),
      .span_x      (span_x),
      .span_y      (span_y),
      .col_o       (col_s1),
      .row_o       (row_s1),
      .tok_o       (tok_s1),
      .scan_col_o  (scan_col)
   );

   rrpr_shade #(
      .COORD_BITS (COORD_BITS),
      .OFF_BITS   (OFF_BITS)
   ) u_shade (
      .clock     (clock),
      .reset     (reset),
      .col       (col_s1),
      .row       (row_s1),
      .tok_s1    (tok_s1),
      .left_x    (left_x),
      .top_y     (top_y),
      .cx        (cx),
      .cy        (cy),
      .off_x     (off_x),
      .off_y     (off_y),
      .rad_sq    (rad_sq),
      .fill      (fill),
      .outside   (outside),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_color (rsp_ch.pixel_color),
      .rsp_last  (rsp_ch.last_pixel),
      .adv       (adv)
   );

   // requests are taken whenever the pipe moves
   assign req_ch.ready = adv;

   // a stalled result must hold off new requests
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("request taken while result stalled");

   // every request transfer fills the first stage
   a_req_fills_s1: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> tok_s1.valid)
      else $error("request transfer lost before first stage");

   // scan column never runs past the last column of an unchanged window
   a_col_in_window: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && !csr_ch.valid)
      |=> (scan_col <= (COORD_BITS + 1)'(span_x)))
      else $error("scan column beyond window");

endmodule

`default_nettype wire
